// ===== design/mpirq_pkg.sv =====
`timescale 1ns / 1ps

package mpirq_pkg;

  // item opcodes
  typedef enum logic {
    OP_START = 1'b0,
    OP_BYTE  = 1'b1
  } mpirq_op_e;

  // query modes
  typedef enum logic {
    MODE_PCI = 1'b0,
    MODE_ISA = 1'b1
  } mpirq_mode_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_FOUND    = 3'd0,
    ST_NOTFOUND = 3'd1,
    ST_RSV_POL  = 3'd2,
    ST_RSV_TRIG = 3'd3,
    ST_BAD_TYPE = 3'd4
  } mpirq_status_e;

  // entry types
  localparam logic [2:0] TYPE_PROC  = 3'd0;
  localparam logic [2:0] TYPE_BUS   = 3'd1;
  localparam logic [2:0] TYPE_IOINT = 3'd3;
  localparam logic [7:0] TYPE_MAX   = 8'd4;

  // last byte position of an entry, and of the captured bytes
  localparam logic [4:0] PROC_LAST  = 5'd19;
  localparam logic [4:0] OTHER_LAST = 5'd7;
  localparam logic [4:0] CAP_LAST   = 5'd6;

  // two-bit flag codes
  localparam logic [1:0] FLAG_RSV  = 2'b10;
  localparam logic [1:0] FLAG_HIGH = 2'b11;

  // bus name prefix of the ISA bus
  localparam logic [7:0] CHAR_I = 8'h49;
  localparam logic [7:0] CHAR_S = 8'h53;
  localparam logic [7:0] CHAR_A = 8'h41;

  // one input word
  typedef struct packed {
    logic       opcode;
    logic       query_mode;
    logic [7:0] query_bus;
    logic [4:0] query_slot;
    logic [1:0] query_func;
    logic [7:0] query_isa_irq;
    logic [7:0] table_byte;
  } mpirq_item_t;

  // one result word
  typedef struct packed {
    logic [2:0] status;
    logic [7:0] ioapic_id;
    logic [7:0] ioapic_pin;
    logic       pol_low;
    logic       trig_level;
  } mpirq_res_t;

endpackage

// ===== design/mpirq_in_if.sv =====
`timescale 1ns / 1ps

interface mpirq_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic       query_mode;
  logic [7:0] query_bus;
  logic [4:0] query_slot;
  logic [1:0] query_func;
  logic [7:0] query_isa_irq;
  logic [7:0] table_byte;

  modport source (
    output valid, opcode, query_mode, query_bus, query_slot, query_func,
           query_isa_irq, table_byte,
    input  ready
  );

  modport sink (
    input  valid, opcode, query_mode, query_bus, query_slot, query_func,
           query_isa_irq, table_byte,
    output ready
  );
endinterface

// ===== design/mpirq_out_if.sv =====
`timescale 1ns / 1ps

interface mpirq_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] ioapic_id;
  logic [7:0] ioapic_pin;
  logic       pol_low;
  logic       trig_level;

  modport source (
    output valid, status, ioapic_id, ioapic_pin, pol_low, trig_level,
    input  ready
  );

  modport sink (
    input  valid, status, ioapic_id, ioapic_pin, pol_low, trig_level,
    output ready
  );
endinterface

// ===== design/mpirq_parse.sv =====
`timescale 1ns / 1ps

// entry parser: holds the search state and handles one word per step
module mpirq_parse (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [15:0]        tbl_entries_i,
  input  logic               step_i,
  input  mpirq_pkg::mpirq_item_t item_i,
  output logic               res_valid_o,
  output mpirq_pkg::mpirq_res_t  res_o
);

  logic [4:0]  pos_q, pos_d;
  logic [2:0]  type_q, type_d;
  logic [15:0] left_q, left_d;
  logic [7:0]  cap_q [6];
  logic [7:0]  cap_d [6];
  logic [8:0]  isa_q, isa_d;
  logic        done_q, done_d;
  logic        mode_q, mode_d;
  logic [7:0]  bus_q, bus_d;
  logic [4:0]  slot_q, slot_d;
  logic [1:0]  func_q, func_d;
  logic [7:0]  irq_q, irq_d;

  // next state and result
  always_comb begin
    logic [2:0] cur_type;
    logic       last;
    logic       hit;
    logic [1:0] pol;
    logic [1:0] trig;

    pos_d  = pos_q;
    type_d = type_q;
    left_d = left_q;
    cap_d  = cap_q;
    isa_d  = isa_q;
    done_d = done_q;
    mode_d = mode_q;
    bus_d  = bus_q;
    slot_d = slot_q;
    func_d = func_q;
    irq_d  = irq_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.status = mpirq_pkg::ST_NOTFOUND;
    cur_type = (pos_q == 5'd0) ? item_i.table_byte[2:0] : type_q;
    last = (cur_type == mpirq_pkg::TYPE_PROC) ? (pos_q == mpirq_pkg::PROC_LAST)
                                              : (pos_q == mpirq_pkg::OTHER_LAST);
    pol  = cap_q[1][1:0];
    trig = cap_q[1][3:2];
    if (mode_q == mpirq_pkg::MODE_PCI) begin
      hit = (cap_q[3] == bus_q) && (cap_q[4][6:2] == slot_q) && (cap_q[4][1:0] == func_q);
    end else begin
      hit = isa_q[8] && (cap_q[3] == isa_q[7:0]) && (cap_q[4] == irq_q);
    end

    if (step_i) begin
      if (item_i.opcode == mpirq_pkg::OP_START) begin
        // load a new query and restart the walk
        mode_d = item_i.query_mode;
        bus_d  = item_i.query_bus;
        slot_d = item_i.query_slot;
        func_d = item_i.query_func;
        irq_d  = item_i.query_isa_irq;
        left_d = tbl_entries_i;
        pos_d  = '0;
        type_d = '0;
        for (int i = 0; i < 6; i++) cap_d[i] = '0;
        isa_d  = '0;
        done_d = (tbl_entries_i == 16'd0);
        res_valid_o = (tbl_entries_i == 16'd0);
      end else if (!done_q) begin
        if (pos_q == 5'd0 && item_i.table_byte > mpirq_pkg::TYPE_MAX) begin
          // unknown entry type
          done_d = 1'b1;
          res_valid_o  = 1'b1;
          res_o.status = mpirq_pkg::ST_BAD_TYPE;
        end else begin
          if (pos_q == 5'd0) type_d = cur_type;
          if (pos_q != 5'd0 && pos_q <= mpirq_pkg::CAP_LAST) begin
            cap_d[pos_q[2:0] - 3'd1] = item_i.table_byte;
          end
          if (!last) begin
            pos_d = pos_q + 5'd1;
          end else begin
            // end of entry
            pos_d  = '0;
            left_d = left_q - 16'd1;
            if (cur_type == mpirq_pkg::TYPE_BUS && mode_q == mpirq_pkg::MODE_ISA) begin
              if (cap_q[1] == mpirq_pkg::CHAR_I && cap_q[2] == mpirq_pkg::CHAR_S
                  && cap_q[3] == mpirq_pkg::CHAR_A) begin
                isa_d = {1'b1, cap_q[0]};
              end
            end
            if (cur_type == mpirq_pkg::TYPE_IOINT && hit) begin
              done_d = 1'b1;
              res_valid_o = 1'b1;
              if (pol == mpirq_pkg::FLAG_RSV) begin
                res_o.status = mpirq_pkg::ST_RSV_POL;
              end else if (trig == mpirq_pkg::FLAG_RSV) begin
                res_o.status = mpirq_pkg::ST_RSV_TRIG;
              end else begin
                res_o.status     = mpirq_pkg::ST_FOUND;
                res_o.ioapic_id  = cap_q[5];
                res_o.ioapic_pin = item_i.table_byte;
                res_o.pol_low    = (pol == mpirq_pkg::FLAG_HIGH);
                res_o.trig_level = (trig == mpirq_pkg::FLAG_HIGH);
              end
            end else if (left_q == 16'd1) begin
              // table exhausted
              done_d = 1'b1;
              res_valid_o = 1'b1;
            end
          end
        end
      end
    end
  end

  // search state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      type_q <= '0;
      left_q <= '0;
      for (int i = 0; i < 6; i++) cap_q[i] <= '0;
      isa_q  <= '0;
      done_q <= 1'b1;
      mode_q <= mpirq_pkg::MODE_PCI;
      bus_q  <= '0;
      slot_q <= '0;
      func_q <= '0;
      irq_q  <= '0;
    end else begin
      pos_q  <= pos_d;
      type_q <= type_d;
      left_q <= left_d;
      cap_q  <= cap_d;
      isa_q  <= isa_d;
      done_q <= done_d;
      mode_q <= mode_d;
      bus_q  <= bus_d;
      slot_q <= slot_d;
      func_q <= func_d;
      irq_q  <= irq_d;
    end
  end

endmodule

// ===== design/mp_table_irq_route_lookup.sv =====
`timescale 1ns / 1ps

// MP-table interrupt routing lookup. A start word loads a PCI bus/slot/function
// or ISA irq query; table words then stream the entry area one byte each, and
// the block answers once per search with the matching I/O APIC id and pin,
// polarity and trigger, or a not-found / reserved-code / bad-type status.
// One word is taken every cycle unless a waiting result stalls the input. Each
// byte is handled by the entry parser between an input and a result register,
// so the word that decides a result passes the input register and the parser
// before the result register holds it. While a result word waits on the
// output, the input register can hold one more word, then the input stalls
// until the result is taken. The entry count register is sampled by a start.
module mp_table_irq_route_lookup (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  mpirq_in_if.sink    in_i,
  mpirq_out_if.source out_o
);

  logic [15:0]           tbl_entries_q;
  logic                  s1_valid_q;
  mpirq_pkg::mpirq_item_t s1_item_q;
  logic                  out_valid_q;
  mpirq_pkg::mpirq_res_t  out_res_q;
  logic                  advance;
  logic                  step;
  logic                  res_valid;
  mpirq_pkg::mpirq_res_t  res;

  assign advance    = !out_valid_q || out_o.ready;
  assign step       = s1_valid_q && advance;
  assign in_i.ready = !s1_valid_q || advance;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tbl_entries_q <= '0;
    end else if (cfg_we_i) begin
      tbl_entries_q <= cfg_wdata_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_item_q.opcode        <= in_i.opcode;
      s1_item_q.query_mode    <= in_i.query_mode;
      s1_item_q.query_bus     <= in_i.query_bus;
      s1_item_q.query_slot    <= in_i.query_slot;
      s1_item_q.query_func    <= in_i.query_func;
      s1_item_q.query_isa_irq <= in_i.query_isa_irq;
      s1_item_q.table_byte    <= in_i.table_byte;
    end
  end

  mpirq_parse u_parse (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tbl_entries_i (tbl_entries_q),
    .step_i        (step),
    .item_i        (s1_item_q),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = out_res_q.status;
  assign out_o.ioapic_id  = out_res_q.ioapic_id;
  assign out_o.ioapic_pin = out_res_q.ioapic_pin;
  assign out_o.pol_low    = out_res_q.pol_low;
  assign out_o.trig_level = out_res_q.trig_level;

endmodule

// ===== design/mpirq_checker.sv =====
`timescale 1ns / 1ps

module mpirq_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [2:0] status_i,
  input logic [7:0] ioapic_id_i,
  input logic [7:0] ioapic_pin_i,
  input logic       pol_low_i,
  input logic       trig_level_i
);

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i)
      && $stable(ioapic_id_i) && $stable(ioapic_pin_i))
    else $error("stalled result changed");

  // status code in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> status_i <= 3'(mpirq_pkg::ST_BAD_TYPE))
    else $error("status out of range");

  // routing fields are zero unless found
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != 3'(mpirq_pkg::ST_FOUND) |->
      ioapic_id_i == 8'd0 && ioapic_pin_i == 8'd0 && !pol_low_i && !trig_level_i)
    else $error("routing fields set without a match");

  // a new result follows a word accepted through the input and result registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result without a word");

endmodule

bind mp_table_irq_route_lookup mpirq_checker u_mpirq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .status_i     (out_o.status),
  .ioapic_id_i  (out_o.ioapic_id),
  .ioapic_pin_i (out_o.ioapic_pin),
  .pol_low_i    (out_o.pol_low),
  .trig_level_i (out_o.trig_level)
);
